// ----- hw/rtl/itra_pkg.sv -----
`default_nettype none

package itra_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int VALUE_IN_BITS = 32;
   localparam int BASE_BITS     = 6;
   localparam int DIGIT_BITS    = 6;
   localparam int CHAR_BITS     = 7;
   localparam int INDEX_BITS    = $clog2(VALUE_BITS);
   localparam int COUNT_BITS    = $clog2(VALUE_BITS + 1);

   localparam logic [CHAR_BITS-1:0]  CH_ZERO           = 7'h30;
   localparam logic [CHAR_BITS-1:0]  CH_LOWER_A        = 7'h61;
   localparam logic [CHAR_BITS-1:0]  CH_MINUS          = 7'h2d;
   localparam logic [BASE_BITS-1:0]  DEFAULT_RADIX     = 6'd10;
   localparam logic [BASE_BITS-1:0]  MIN_RADIX         = 6'd2;
   localparam logic [BASE_BITS-1:0]  MAX_RADIX         = 6'd36;
   localparam logic [DIGIT_BITS-1:0] MAX_DECIMAL_DIGIT = 6'd9;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] wide;
      wide = {1'b0, d};
      if (d > MAX_DECIMAL_DIGIT) begin
         return wide - CHAR_BITS'(DEFAULT_RADIX) + CH_LOWER_A;
      end
      return wide + CH_ZERO;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itra_divider.sv -----
`default_nettype none

module itra_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [itra_pkg::VALUE_BITS-1:0]      dividend,
   input  wire logic [itra_pkg::BASE_BITS-1:0]       radix,
   output logic                                      done,
   output logic [itra_pkg::VALUE_BITS-1:0]           quotient,
   output logic [itra_pkg::DIGIT_BITS-1:0]           remainder
);

   logic                                 run_ff, run_in;
   logic                                 done_ff, done_in;
   logic [itra_pkg::INDEX_BITS-1:0]      step_ff, step_in;
   logic [itra_pkg::VALUE_BITS-1:0]      quot_ff, quot_in;
   logic [itra_pkg::DIGIT_BITS-1:0]      rem_ff, rem_in;
   logic [itra_pkg::BASE_BITS-1:0]       radix_ff, radix_in;

   logic [itra_pkg::DIGIT_BITS:0]        partial;
   logic [itra_pkg::DIGIT_BITS:0]        diff;
   logic                                 fits;

   always_comb begin
      partial = {rem_ff, quot_ff[itra_pkg::VALUE_BITS-1]};
      fits    = partial >= {1'b0, radix_ff};
      diff    = partial - {1'b0, radix_ff};
   end

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      if (start) begin
         run_in   = 1'b1;
         step_in  = itra_pkg::INDEX_BITS'(itra_pkg::VALUE_BITS - 1);
         quot_in  = dividend;
         rem_in   = '0;
         radix_in = radix;
      end else if (run_ff) begin
         quot_in = {quot_ff[itra_pkg::VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[itra_pkg::DIGIT_BITS-1:0] : partial[itra_pkg::DIGIT_BITS-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         quot_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
         quot_ff <= quot_in;
      end
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/itra_digit_store.sv -----
`default_nettype none

module itra_digit_store (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [itra_pkg::INDEX_BITS-1:0]      wr_addr,
   input  wire logic [itra_pkg::DIGIT_BITS-1:0]      wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [itra_pkg::INDEX_BITS-1:0]      rd_addr,
   output logic [itra_pkg::DIGIT_BITS-1:0]           rd_data
);

   logic [itra_pkg::DIGIT_BITS-1:0] mem [itra_pkg::VALUE_BITS];
   logic [itra_pkg::DIGIT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_radix_ascii.sv -----
`default_nettype none

// Channel    Ports                                        Handshake
// request    req_value, req_base, req_negative            start high while busy low
// response   rsp_character, rsp_last                      rsp_valid, one cycle each
//
// A zero value gives its single character in the cycle after the request.
// Each digit comes from the shared bit-serial divider, and each character then passes
// through the READ and EMIT states via the digit store's registered read port.
// Reset is synchronous and clears the control state; the digit store is not cleared.
// The receiver cannot stall, so every response is taken in the cycle it is shown.

module integer_to_radix_ascii (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [itra_pkg::VALUE_IN_BITS-1:0]   req_value,
   input  wire logic [itra_pkg::BASE_BITS-1:0]       req_base,
   input  wire logic                                 req_negative,
   output logic                                      rsp_valid,
   output logic [itra_pkg::CHAR_BITS-1:0]            rsp_character,
   output logic                                      rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type                            state_ff, state_in;
   logic [itra_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic [itra_pkg::BASE_BITS-1:0]       radix_ff, radix_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [itra_pkg::CHAR_BITS-1:0]       rsp_character_ff, rsp_character_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic [itra_pkg::VALUE_BITS+itra_pkg::VALUE_IN_BITS-1:0] value_wide;
   logic [itra_pkg::VALUE_BITS-1:0]      value_masked;
   logic [itra_pkg::VALUE_BITS-1:0]      magnitude;
   logic [itra_pkg::BASE_BITS-1:0]       radix_fixed;

   logic                                 div_start;
   logic [itra_pkg::VALUE_BITS-1:0]      div_dividend;
   logic                                 div_done;
   logic [itra_pkg::VALUE_BITS-1:0]      div_quotient;
   logic [itra_pkg::DIGIT_BITS-1:0]      div_remainder;

   logic                                 wr_en;
   logic                                 rd_en;
   logic [itra_pkg::COUNT_BITS-1:0]      rd_index;
   logic [itra_pkg::DIGIT_BITS-1:0]      rd_data;

   always_comb begin
      value_wide   = {{itra_pkg::VALUE_BITS{1'b0}}, req_value};
      value_masked = value_wide[itra_pkg::VALUE_BITS-1:0];
      magnitude    = req_negative ? ('0 - value_masked) : value_masked;
      if (req_base < itra_pkg::MIN_RADIX || req_base > itra_pkg::MAX_RADIX) begin
         radix_fixed = itra_pkg::DEFAULT_RADIX;
      end else begin
         radix_fixed = req_base;
      end
      rd_index = count_ff - 1'b1;
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      radix_in         = radix_ff;
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      div_start        = 1'b0;
      div_dividend     = div_quotient;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            div_dividend = magnitude;
            if (start) begin
               if (value_masked == '0) begin
                  rsp_valid_in     = 1'b1;
                  rsp_character_in = itra_pkg::CH_ZERO;
                  rsp_last_in      = 1'b1;
               end else begin
                  if (req_negative) begin
                     rsp_valid_in     = 1'b1;
                     rsp_character_in = itra_pkg::CH_MINUS;
                     rsp_last_in      = 1'b0;
                  end
                  div_start = 1'b1;
                  radix_in  = radix_fixed;
                  count_in  = '0;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (div_quotient != '0) begin
                  div_start = 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = itra_pkg::digit_char(rd_data);
            rsp_last_in      = count_ff == itra_pkg::COUNT_BITS'(1);
            count_in         = count_ff - 1'b1;
            state_in         = rsp_last_in ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      radix_ff         <= radix_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   itra_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_start && state_ff == ST_IDLE ? radix_fixed : radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   itra_digit_store u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[itra_pkg::INDEX_BITS-1:0]),
      .wr_data (div_remainder),
      .rd_en   (rd_en),
      .rd_addr (rd_index[itra_pkg::INDEX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign busy          = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/itra_checker.sv -----
`default_nettype none

module itra_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 busy,
   input  wire logic [itra_pkg::VALUE_IN_BITS-1:0]   req_value,
   input  wire logic [itra_pkg::BASE_BITS-1:0]       req_base,
   input  wire logic                                 req_negative,
   input  wire logic                                 rsp_valid,
   input  wire logic [itra_pkg::CHAR_BITS-1:0]       rsp_character,
   input  wire logic                                 rsp_last
);

   // A zero value answers with a lone final '0' in the next cycle.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_value == '0
      |=> rsp_valid && rsp_character == itra_pkg::CH_ZERO && rsp_last)
      else $error("zero value did not give a single final zero");

   // Further characters of a number follow, so the block must still be busy.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("block idle while a number is unfinished");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == itra_pkg::CH_MINUS |-> !rsp_last)
      else $error("minus sign marked as final character");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_character == itra_pkg::CH_MINUS
         || (rsp_character >= itra_pkg::CH_ZERO && rsp_character <= 7'h39)
         || (rsp_character >= itra_pkg::CH_LOWER_A && rsp_character <= 7'h7a))
      else $error("character outside the digit set");

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (.*);

`default_nettype wire

// ----- verif/integer_to_radix_ascii_tb.sv -----
`default_nettype none

module integer_to_radix_ascii_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itra_pkg::*;

   localparam int RANDOM_REQUESTS = 388;
   localparam int PHASES          = 4;
   localparam int DRAIN_CYCLES    = 100;
   localparam int CYCLE_LIMIT     = 2_500_000;
   localparam int TEXT_BYTES      = 12;
   localparam int DIRECTED_ROWS   = 23;

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } text_char_type;

   typedef struct packed {
      logic [VALUE_IN_BITS-1:0] value;
      logic [BASE_BITS-1:0]     base;
      logic                     negative;
      logic [8*TEXT_BYTES-1:0]  text;
   } request_row_type;

   // Rows with an empty text are checked against the predictor instead.
   request_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'd0,          6'd10, 1'b0, "0"},
      '{32'd0,          6'd2,  1'b1, "0"},
      '{32'd0,          6'd63, 1'b1, "0"},
      '{32'd1,          6'd2,  1'b0, "1"},
      '{32'd9,          6'd10, 1'b0, "9"},
      '{32'd10,         6'd11, 1'b0, "a"},
      '{32'd35,         6'd36, 1'b0, "z"},
      '{32'd255,        6'd16, 1'b0, "ff"},
      '{32'd8,          6'd8,  1'b0, "10"},
      '{32'd123,        6'd0,  1'b0, "123"},
      '{32'd123,        6'd1,  1'b0, "123"},
      '{32'd123,        6'd37, 1'b0, "123"},
      '{32'd123,        6'd63, 1'b0, "123"},
      '{32'hffff_ffff,  6'd16, 1'b0, "ffffffff"},
      '{32'hffff_ffff,  6'd10, 1'b0, "4294967295"},
      '{32'hffff_ffff,  6'd2,  1'b0, ""},
      '{32'hffff_ffff,  6'd36, 1'b0, ""},
      '{32'hffff_ffff,  6'd10, 1'b1, "-1"},
      '{32'h8000_0000,  6'd10, 1'b1, "-2147483648"},
      '{32'h8000_0000,  6'd2,  1'b1, ""},
      '{32'd5,          6'd10, 1'b1, "-4294967291"},
      '{32'h7fff_ffff,  6'd8,  1'b1, ""},
      '{32'hdead_beef,  6'd36, 1'b0, ""}
   };

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     start        = 1'b0;
   logic [VALUE_IN_BITS-1:0] req_value    = '0;
   logic [BASE_BITS-1:0]     req_base     = '0;
   logic                     req_negative = 1'b0;
   logic                     busy;
   logic                     rsp_valid;
   logic [CHAR_BITS-1:0]     rsp_character;
   logic                     rsp_last;

   text_char_type expected_chars [$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;

   integer_to_radix_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_base      (req_base),
      .req_negative  (req_negative),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_text(input logic [VALUE_IN_BITS-1:0] value,
                                        input logic [BASE_BITS-1:0] base,
                                        input logic negative);
      logic [VALUE_BITS-1:0] magnitude;
      logic [VALUE_BITS-1:0] radix;
      logic [DIGIT_BITS-1:0] digits [$];
      logic [CHAR_BITS-1:0]  digit_ascii;
      magnitude = VALUE_BITS'(value);
      if (magnitude == '0) begin
         expected_chars.push_back({CH_ZERO, 1'b1});
         return;
      end
      if (base < MIN_RADIX || base > MAX_RADIX) begin
         radix = VALUE_BITS'(DEFAULT_RADIX);
      end else begin
         radix = VALUE_BITS'(base);
      end
      if (negative) begin
         magnitude = -magnitude;
         expected_chars.push_back({CH_MINUS, 1'b0});
      end
      do begin
         digits.push_front(DIGIT_BITS'(magnitude % radix));
         magnitude = magnitude / radix;
      end while (magnitude != '0);
      foreach (digits[i]) begin
         if (digits[i] > MAX_DECIMAL_DIGIT) begin
            digit_ascii = CHAR_BITS'(digits[i]) - CHAR_BITS'(DEFAULT_RADIX) + CH_LOWER_A;
         end else begin
            digit_ascii = CHAR_BITS'(digits[i]) + CH_ZERO;
         end
         expected_chars.push_back({digit_ascii, i == digits.size() - 1});
      end
   endfunction

   function automatic void queue_typed_text(input logic [8*TEXT_BYTES-1:0] text);
      int top;
      top = TEXT_BYTES - 1;
      while (top > 0 && text[top*8 +: 8] == 8'h00) begin
         top--;
      end
      for (int i = top; i >= 0; i--) begin
         expected_chars.push_back({text[i*8 +: CHAR_BITS], i == 0});
      end
   endfunction

   // The request stays up across back-to-back items, so start is written once per edge.
   task automatic send_request(input logic [VALUE_IN_BITS-1:0] value,
                               input logic [BASE_BITS-1:0] base,
                               input logic negative,
                               input logic [8*TEXT_BYTES-1:0] text,
                               input int idle_pct);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
      start        <= 1'b1;
      req_value    <= value;
      req_base     <= base;
      req_negative <= negative;
      do begin
         @(posedge clock);
      end while (busy);
      if (text != '0 && VALUE_BITS == 32) begin
         queue_typed_text(text);
      end else begin
         predict_text(value, base, negative);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            $error("character: expected none, actual %h", rsp_character);
            mismatch_count++;
         end else begin
            if (rsp_character !== expected_chars[0].character) begin
               $error("character: expected %h, actual %h",
                      expected_chars[0].character, rsp_character);
               mismatch_count++;
            end
            if (rsp_last !== expected_chars[0].last) begin
               $error("last: expected %b, actual %b", expected_chars[0].last, rsp_last);
               mismatch_count++;
            end
            void'(expected_chars.pop_front());
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL integer_to_radix_ascii");
      $finish;
   end

   initial begin
      int                       idle_pct [PHASES] = '{0, 64, 0, 15};
      logic [VALUE_IN_BITS-1:0] value;
      logic [BASE_BITS-1:0]     base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].value, directed_rows[r].base,
                      directed_rows[r].negative, directed_rows[r].text, 0);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         for (int n = 0; n < RANDOM_REQUESTS / PHASES; n++) begin
            case ($urandom_range(9))
               0:       value = '0;
               1:       value = $urandom_range(40);
               2:       value = 32'd1 << $urandom_range(VALUE_IN_BITS - 1);
               3:       value = 32'hffff_ffff - $urandom_range(3);
               4:       value = 32'h8000_0000 ^ $urandom_range(1);
               default: value = $urandom;
            endcase
            case ($urandom_range(9))
               0:       base = DEFAULT_RADIX;
               1:       base = MIN_RADIX;
               2:       base = 6'd16;
               3:       base = MAX_RADIX;
               4, 5:    base = BASE_BITS'($urandom_range(63));
               default: base = BASE_BITS'($urandom_range(MAX_RADIX, MIN_RADIX));
            endcase
            send_request(value, base, 1'($urandom_range(1)), '0, idle_pct[phase]);
         end
      end
      start <= 1'b0;

      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS integer_to_radix_ascii");
      end else begin
         $display("FAIL integer_to_radix_ascii");
      end
      $finish;
   end

endmodule

`default_nettype wire
